>>> rtl/ilp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilp_pkg: shared types and constants of the integer literal parser
// value width, phase and radix codes, character codes, parse state record
// ----------------------------------------------------------------------------
package ilp_pkg;

    localparam int VALUE_WIDTH = 64;

    typedef logic [VALUE_WIDTH-1:0] value_t;
    typedef logic [7:0]             char_t;
    typedef logic [3:0]             digit_t;

    // where we are within the current literal
    typedef enum logic [2:0] {
        PH_FIRST  = 3'b001,
        PH_ZERO   = 3'b010,
        PH_DIGITS = 3'b100
    } phase_t;

    typedef enum logic [2:0] {
        RX_DEC = 3'b001,
        RX_OCT = 3'b010,
        RX_HEX = 3'b100
    } radix_t;

    localparam char_t CH_ZERO  = 8'h30;
    localparam char_t CH_SEVEN = 8'h37;
    localparam char_t CH_NINE  = 8'h39;
    localparam char_t CH_UC_A  = 8'h41;
    localparam char_t CH_UC_F  = 8'h46;
    localparam char_t CH_UC_X  = 8'h58;
    localparam char_t CH_LC_A  = 8'h61;
    localparam char_t CH_LC_F  = 8'h66;
    localparam char_t CH_LC_X  = 8'h78;

    localparam digit_t DIGIT_TEN = 4'd10;

    typedef struct packed {
        phase_t phase;
        radix_t radix;
        logic   halted;
        value_t acc;
    } parse_state_t;

    localparam parse_state_t STATE_IDLE = '{
        phase:  PH_FIRST,
        radix:  RX_DEC,
        halted: 1'b0,
        acc:    '0
    };

endpackage

>>> rtl/ilp_char_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilp_char_if: character channel
// one byte of literal text per word, with a flag on the final byte
// ----------------------------------------------------------------------------
interface ilp_char_if;

    logic              valid;
    logic              ready;
    ilp_pkg::char_t    char_code;
    logic              last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);

endinterface

>>> rtl/ilp_value_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilp_value_if: result channel
// one parsed value per word
// ----------------------------------------------------------------------------
interface ilp_value_if;

    logic              valid;
    logic              ready;
    ilp_pkg::value_t   value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);

endinterface

>>> rtl/ilp_digit_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilp_digit_step: one character of parsing
// base selection, digit decode and accumulate, all combinational
// ----------------------------------------------------------------------------
module ilp_digit_step
(
    input  ilp_pkg::parse_state_t state,
    input  ilp_pkg::char_t        char_code,
    input  logic                  last_char,
    output ilp_pkg::parse_state_t state_next,
    output ilp_pkg::value_t       value
);
    import ilp_pkg::*;

    parse_state_t upd;
    logic         take;
    logic         digit_ok;
    digit_t       digit;
    value_t       digit_ext;
    value_t       scaled;

    always_comb
    begin
        upd       = state;
        take      = 1'b1;
        digit_ok  = 1'b0;
        digit     = '0;
        scaled    = state.acc;

        case (state.phase)
            PH_FIRST:
            begin
                if (char_code == CH_ZERO && !last_char)
                begin
                    upd.phase = PH_ZERO;
                    take      = 1'b0;
                end
                else
                begin
                    upd.radix = RX_DEC;
                    upd.phase = PH_DIGITS;
                end
            end
            PH_ZERO:
            begin
                upd.phase = PH_DIGITS;
                if (char_code == CH_LC_X || char_code == CH_UC_X)
                begin
                    upd.radix = RX_HEX;
                    take      = 1'b0;
                end
                else
                begin
                    upd.radix = RX_OCT;
                end
            end
            default:
            begin
                take = 1'b1;
            end
        endcase

        // digit decode in the radix now in force
        case (upd.radix)
            RX_HEX:
            begin
                if (char_code inside {[CH_ZERO:CH_NINE]})
                begin
                    digit_ok = 1'b1;
                    digit    = digit_t'(char_code - CH_ZERO);
                end
                else if (char_code inside {[CH_LC_A:CH_LC_F]})
                begin
                    digit_ok = 1'b1;
                    digit    = digit_t'(char_code - CH_LC_A) + DIGIT_TEN;
                end
                else if (char_code inside {[CH_UC_A:CH_UC_F]})
                begin
                    digit_ok = 1'b1;
                    digit    = digit_t'(char_code - CH_UC_A) + DIGIT_TEN;
                end
                scaled = state.acc << 4;
            end
            RX_OCT:
            begin
                if (char_code inside {[CH_ZERO:CH_SEVEN]})
                begin
                    digit_ok = 1'b1;
                    digit    = digit_t'(char_code - CH_ZERO);
                end
                scaled = state.acc << 3;
            end
            default:
            begin
                if (char_code inside {[CH_ZERO:CH_NINE]})
                begin
                    digit_ok = 1'b1;
                    digit    = digit_t'(char_code - CH_ZERO);
                end
                // times ten as 8x + 2x
                scaled = (state.acc << 3) + (state.acc << 1);
            end
        endcase

        digit_ext = value_t'(digit);

        if (take && !state.halted)
        begin
            if (digit_ok)
                upd.acc = scaled + digit_ext;
            else
                upd.halted = 1'b1;
        end
    end

    assign value      = upd.acc;
    assign state_next = last_char ? STATE_IDLE : upd;

endmodule

>>> rtl/integer_literal_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_literal_parser_unit: C-style unsigned integer literal parser
// bytes of literal text in, one parsed value out per literal
// ----------------------------------------------------------------------------
// usage
//   literal: one character word per transfer (char_code, last_char). base is
//     picked from the leading characters: "0x"/"0X" hex, '0' then more text
//     octal, otherwise decimal. parsing stops quietly at the first byte that
//     is not a digit of that base (suffixes like u or L are skipped)
//   result: one word carrying value, produced for each word with last_char
//     set; value wraps modulo 2^VALUE_WIDTH
//   throughput: one character per cycle across literal borders, except while
//     a final character waits on a held result; the last character goes
//     into the input register, then its value into the result register
//   the work per character is one shift-add through the digit step, between
//     the input register and the parse state / result register
//   stall: a held result stalls only a final character waiting in the input
//     register; ordinary characters keep flowing, and ready drops only while
//     the input register holds a final character and the result is full
//   reset: asynchronous, clears the input and result valid flags and puts
//     the parse state back to "expecting first character", decimal, zero
// ----------------------------------------------------------------------------
module integer_literal_parser_unit
(
    input  logic        clk,
    input  logic        rst_n,
    ilp_char_if.sink    literal,
    ilp_value_if.source result
);
    import ilp_pkg::*;

    // input register
    logic          in_valid_reg;
    char_t         in_char_reg;
    logic          in_last_reg;

    // parse state, carried between characters
    parse_state_t  state_reg;
    parse_state_t  state_next;
    value_t        step_value;

    // result register
    logic          out_valid_reg;
    value_t        out_value_reg;

    logic          out_free;
    logic          step_fire;
    logic          in_take;

    // a final character needs a free result slot, others always advance
    assign out_free  = !out_valid_reg || result.ready;
    assign step_fire = in_valid_reg && (!in_last_reg || out_free);
    assign literal.ready = !in_valid_reg || step_fire;
    assign in_take   = literal.valid && literal.ready;

    ilp_digit_step u_step
    (
        .state      (state_reg),
        .char_code  (in_char_reg),
        .last_char  (in_last_reg),
        .state_next (state_next),
        .value      (step_value)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (literal.ready)
        begin
            in_valid_reg <= literal.valid;
        end
    end

    // payload of the input register
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_char_reg <= literal.char_code;
            in_last_reg <= literal.last_char;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_IDLE;
        end
        else if (step_fire)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step_fire && in_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_fire && in_last_reg)
        begin
            out_value_reg <= step_value;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.value = out_value_reg;

`ifndef SYNTHESIS
    // parse state is back at idle after a literal closes
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        step_fire && in_last_reg |=>
            state_reg.phase == PH_FIRST && !state_reg.halted && state_reg.acc == '0)
        else $error("parse state not cleared after final character");

    // a final character never overwrites an untaken result
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && in_last_reg && out_valid_reg && !result.ready |-> !step_fire)
        else $error("final character advanced over a stalled result");

    // a new result comes only from a final character
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(step_fire && in_last_reg))
        else $error("result raised without a final character");

    // once halted, the accumulator holds until the literal ends
    a_halt_holds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.halted && step_fire && !in_last_reg |=> $stable(state_reg.acc))
        else $error("accumulator moved after an invalid digit");
`endif

endmodule
